// ===== src/longest_items_reaching_target_sum_unit_defines.svh =====
// assertion helpers for the longest items reaching target sum unit
`ifndef LONGEST_ITEMS_REACHING_TARGET_SUM_UNIT_DEFINES_SVH
`define LONGEST_ITEMS_REACHING_TARGET_SUM_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define LIRTS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LIRTS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define LIRTS_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define LIRTS_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// ===== src/lirts_pkg.sv =====
package lirts_pkg;

  // default heap capacity
  localparam int unsigned DEPTH_DEFAULT = 1024;

  // fixed field widths
  localparam int unsigned LEN_W     = 31;
  localparam int unsigned SUM_OUT_W = 41;
  localparam int unsigned CNT_OUT_W = 11;

  // target register value after reset
  localparam logic [SUM_OUT_W-1:0] TARGET_RESET = 41'd1;

  // one input item
  typedef struct packed {
    logic [LEN_W-1:0] item_length;
    logic             is_last;
  } item_t;

  // one result item
  typedef struct packed {
    logic [CNT_OUT_W-1:0] selected_count;
    logic [SUM_OUT_W-1:0] selected_sum;
    logic                 overflowed;
  } result_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_UP,
    S_UP_FIN,
    S_POP_RD,
    S_POP_CHK,
    S_DOWN,
    S_FIN
  } state_t;

endpackage

// ===== src/longest_items_reaching_target_sum_unit.sv =====
// operation: after a transfer busy stays high through the insert decision, any sift-up walk
// and, per pop, a pop test and sift-down walk; the result strobe comes in the first idle
// cycle after the set's last item
// one item at a time: busy is high throughout and a new transfer is taken only when idle
// reset: clears count, sum and overflow flag, target to 1; no clearing pass, results never stall
module longest_items_reaching_target_sum_unit #(
  parameter int unsigned HEAP_DEPTH = lirts_pkg::DEPTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  lirts_pkg::item_t                item,
  output logic                            done,
  output lirts_pkg::result_t              result,
  input  logic                            cfg_wr_en,
  input  logic [lirts_pkg::SUM_OUT_W-1:0] cfg_wr_data
);

  localparam int unsigned AW = $clog2(HEAP_DEPTH);

  logic [lirts_pkg::SUM_OUT_W-1:0] target_sum;
  logic                            ram_we;
  logic [AW-1:0]                   ram_waddr;
  logic [lirts_pkg::LEN_W-1:0]     ram_wdata;
  logic [AW-1:0]                   ram_ra;
  logic [AW-1:0]                   ram_rb;
  logic [lirts_pkg::LEN_W-1:0]     ram_qa;
  logic [lirts_pkg::LEN_W-1:0]     ram_qb;

  // target register
  always_ff @(posedge clk) begin
    if (rst) begin
      target_sum <= lirts_pkg::TARGET_RESET;
    end else if (cfg_wr_en) begin
      target_sum <= cfg_wr_data;
    end
  end

  // heap storage
  lirts_heap_ram #(
    .DEPTH (HEAP_DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (ram_ra),
    .raddr_b (ram_rb),
    .rdata_a (ram_qa),
    .rdata_b (ram_qb)
  );

  // sequencer and sum bookkeeping
  lirts_core #(
    .DEPTH (HEAP_DEPTH)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .item      (item),
    .target    (target_sum),
    .busy      (busy),
    .done      (done),
    .result    (result),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_ra    (ram_ra),
    .ram_rb    (ram_rb),
    .ram_qa    (ram_qa),
    .ram_qb    (ram_qb)
  );

endmodule

// ===== src/lirts_heap_ram.sv =====
module lirts_heap_ram #(
  parameter int unsigned DEPTH = lirts_pkg::DEPTH_DEFAULT,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [lirts_pkg::LEN_W-1:0] wdata,
  input  logic [AW-1:0]              raddr_a,
  input  logic [AW-1:0]              raddr_b,
  output logic [lirts_pkg::LEN_W-1:0] rdata_a,
  output logic [lirts_pkg::LEN_W-1:0] rdata_b
);

  logic [lirts_pkg::LEN_W-1:0] mem [DEPTH];

  // one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ===== src/lirts_core.sv =====
`include "longest_items_reaching_target_sum_unit_defines.svh"

module lirts_core #(
  parameter int unsigned DEPTH = lirts_pkg::DEPTH_DEFAULT,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  lirts_pkg::item_t               item,
  input  logic [lirts_pkg::SUM_OUT_W-1:0] target,
  output logic                           busy,
  output logic                           done,
  output lirts_pkg::result_t             result,
  output logic                           ram_we,
  output logic [AW-1:0]                  ram_waddr,
  output logic [lirts_pkg::LEN_W-1:0]    ram_wdata,
  output logic [AW-1:0]                  ram_ra,
  output logic [AW-1:0]                  ram_rb,
  input  logic [lirts_pkg::LEN_W-1:0]    ram_qa,
  input  logic [lirts_pkg::LEN_W-1:0]    ram_qb
);

  localparam int unsigned LW  = lirts_pkg::LEN_W;
  localparam int unsigned CW  = AW + 1;
  localparam int unsigned SW  = (LW + CW > 42) ? LW + CW : 42;
  localparam int unsigned CXW = (CW > lirts_pkg::CNT_OUT_W) ? CW : lirts_pkg::CNT_OUT_W;

  lirts_pkg::state_t state, state_next;

  logic [CW-1:0] heap_size;
  logic [SW-1:0] run_sum;
  logic          ovf;
  logic [LW-1:0] len_q;
  logic          last_q;
  logic [AW-1:0] idx;
  logic [LW-1:0] val;

  // datapath terms
  logic [SW-1:0] target_x;
  logic [SW-1:0] sum_add;
  logic [SW-1:0] sum_sub;
  logic          insert;
  logic          full;
  logic          can_pop;
  logic [AW-1:0] size_ix;
  logic [CW-1:0] size_m1;
  logic [AW-1:0] par_of_size;
  logic [AW-1:0] par;
  logic [AW-1:0] grand;
  logic          up_move;
  logic [AW+1:0] lx;
  logic [AW+1:0] rx;
  logic [AW+1:0] nx;
  logic          l_ok;
  logic [LW-1:0] l_min;
  logic          r_ok;
  logic          down_move;
  logic [LW-1:0] down_val;
  logic [AW-1:0] m_ix;
  logic [AW:0]   cm_l;
  logic [AW:0]   cm_r;
  logic [CXW-1:0] cnt_x;

  // insert decision and pop test
  assign target_x = SW'(target);
  assign sum_add  = run_sum + SW'(len_q);
  assign sum_sub  = run_sum - SW'(ram_qa);
  assign insert   = (heap_size == '0) || (run_sum < target_x) || (ram_qa < len_q);
  assign full     = (heap_size == CW'(DEPTH));
  assign can_pop  = (sum_sub >= target_x);

  // sift-up addressing
  assign size_ix     = heap_size[AW-1:0];
  assign size_m1     = heap_size - CW'(1);
  assign par_of_size = (size_ix - AW'(1)) >> 1;
  assign par         = (idx - AW'(1)) >> 1;
  assign grand       = (par - AW'(1)) >> 1;
  assign up_move     = (ram_qa > val);

  // sift-down child select
  assign lx        = {1'b0, idx, 1'b1};
  assign rx        = lx + (AW+2)'(1);
  assign nx        = {1'b0, heap_size};
  assign l_ok      = (lx < nx) && (ram_qa < val);
  assign l_min     = l_ok ? ram_qa : val;
  assign r_ok      = (rx < nx) && (ram_qb < l_min);
  assign down_move = l_ok || r_ok;
  assign down_val  = r_ok ? ram_qb : ram_qa;
  assign m_ix      = r_ok ? rx[AW-1:0] : lx[AW-1:0];
  assign cm_l      = {m_ix, 1'b1};
  assign cm_r      = cm_l + (AW+1)'(1);

  assign cnt_x = CXW'(heap_size);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      lirts_pkg::S_IDLE: begin
        if (start) state_next = lirts_pkg::S_DECIDE;
      end
      lirts_pkg::S_DECIDE: begin
        if (insert && !full && (heap_size != '0)) state_next = lirts_pkg::S_UP;
        else state_next = lirts_pkg::S_POP_RD;
      end
      lirts_pkg::S_UP: begin
        if (!up_move) state_next = lirts_pkg::S_POP_RD;
        else if (par == '0) state_next = lirts_pkg::S_UP_FIN;
      end
      lirts_pkg::S_UP_FIN: begin
        state_next = lirts_pkg::S_POP_RD;
      end
      lirts_pkg::S_POP_RD: begin
        if (heap_size == '0) state_next = lirts_pkg::S_FIN;
        else state_next = lirts_pkg::S_POP_CHK;
      end
      lirts_pkg::S_POP_CHK: begin
        if (!can_pop) state_next = lirts_pkg::S_FIN;
        else if (heap_size == CW'(1)) state_next = lirts_pkg::S_POP_RD;
        else state_next = lirts_pkg::S_DOWN;
      end
      lirts_pkg::S_DOWN: begin
        if (!down_move) state_next = lirts_pkg::S_POP_RD;
      end
      lirts_pkg::S_FIN: begin
        state_next = lirts_pkg::S_IDLE;
      end
      default: state_next = lirts_pkg::S_IDLE;
    endcase
  end

  // memory port control
  always_comb begin
    busy      = (state != lirts_pkg::S_IDLE);
    ram_we    = 1'b0;
    ram_waddr = idx;
    ram_wdata = val;
    ram_ra    = '0;
    ram_rb    = size_m1[AW-1:0];
    case (state)
      lirts_pkg::S_DECIDE: begin
        if (insert && !full) begin
          if (heap_size == '0) begin
            ram_we    = 1'b1;
            ram_waddr = '0;
            ram_wdata = len_q;
          end else begin
            ram_ra = par_of_size;
          end
        end
      end
      lirts_pkg::S_UP: begin
        ram_we = 1'b1;
        if (up_move) begin
          ram_wdata = ram_qa;
          ram_ra    = grand;
        end
      end
      lirts_pkg::S_UP_FIN: begin
        ram_we = 1'b1;
      end
      lirts_pkg::S_POP_CHK: begin
        ram_ra = AW'(1);
        ram_rb = AW'(2);
      end
      lirts_pkg::S_DOWN: begin
        ram_we = 1'b1;
        if (down_move) begin
          ram_wdata = down_val;
          ram_ra    = cm_l[AW-1:0];
          ram_rb    = cm_r[AW-1:0];
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // control and bookkeeping registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lirts_pkg::S_IDLE;
      heap_size <= '0;
      run_sum   <= '0;
      ovf       <= 1'b0;
      done      <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      case (state)
        lirts_pkg::S_DECIDE: begin
          if (insert) begin
            if (full) begin
              ovf <= 1'b1;
            end else begin
              run_sum   <= sum_add;
              heap_size <= heap_size + CW'(1);
            end
          end
        end
        lirts_pkg::S_POP_CHK: begin
          if (can_pop) begin
            run_sum   <= sum_sub;
            heap_size <= size_m1;
          end
        end
        lirts_pkg::S_FIN: begin
          if (last_q) begin
            done      <= 1'b1;
            heap_size <= '0;
            run_sum   <= '0;
            ovf       <= 1'b0;
          end
        end
        default: begin
          done <= 1'b0;
        end
      endcase
    end
  end

  // item, sift cursor and result payload
  always_ff @(posedge clk) begin
    case (state)
      lirts_pkg::S_IDLE: begin
        if (start) begin
          len_q  <= item.item_length;
          last_q <= item.is_last;
        end
      end
      lirts_pkg::S_DECIDE: begin
        idx <= size_ix;
        val <= len_q;
      end
      lirts_pkg::S_UP: begin
        if (up_move) idx <= par;
      end
      lirts_pkg::S_POP_CHK: begin
        idx <= '0;
        val <= ram_qb;
      end
      lirts_pkg::S_DOWN: begin
        if (down_move) idx <= m_ix;
      end
      lirts_pkg::S_FIN: begin
        result.selected_count <= cnt_x[lirts_pkg::CNT_OUT_W-1:0];
        result.selected_sum   <= (|run_sum[SW-1:lirts_pkg::SUM_OUT_W]) ? '1
                                 : run_sum[lirts_pkg::SUM_OUT_W-1:0];
        result.overflowed     <= ovf;
      end
      default: begin
        idx <= idx;
      end
    endcase
  end

  // checks
  `LIRTS_ASSERT_IMPL(a_size_bound, clk, rst, 1'b1, heap_size <= CW'(DEPTH), "heap count past depth")
  `LIRTS_ASSERT_NEXT(a_accept, clk, rst, start && (state == lirts_pkg::S_IDLE), state == lirts_pkg::S_DECIDE, "accepted item not taken up")
  `LIRTS_ASSERT_NEXT(a_clear, clk, rst, (state == lirts_pkg::S_FIN) && last_q, done && (heap_size == '0) && (run_sum == '0) && !ovf, "set not cleared after last item")
  `LIRTS_ASSERT_IMPL(a_down_idx, clk, rst, state == lirts_pkg::S_DOWN, CW'(idx) < heap_size, "sift-down cursor outside heap")
  `LIRTS_ASSERT_IMPL(a_done_idle, clk, rst, done, state == lirts_pkg::S_IDLE, "result strobe while still working")

endmodule
